### rtl/dnbsm_pkg.sv
package dnbsm_pkg;

    // field widths
    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int DECAY_W = 8;

    // blur arithmetic: three inputs pre-added, eight in the full sum
    localparam int PSUM_W    = 10;
    localparam int SUM_W     = 11;
    localparam int AVG_SHIFT = 3;
    localparam int EDGE_GAP  = 3;
    localparam int MIN_SIZE  = 4;

    // register map
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index REG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_index REG_FRAME_HEIGHT = 2'd1;
    localparam t_cfg_index REG_DECAY_AMOUNT = 2'd2;

    localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 9'd240;
    localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 9'd180;
    localparam logic [DECAY_W-1:0] RST_DECAY_AMOUNT = 8'd4;

    // output queue
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_AW       = 2;
    localparam int OQ_CW       = 3;
    localparam int OQ_FILL_MAX = OQ_DEPTH - 2;

    typedef struct packed {
        logic [PIX_W-1:0] old_pixel;
        logic [PIX_W-1:0] sprite_pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] new_pixel;
        logic             out_valid;
        logic             frame_last;
    } t_out_item;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } t_phase;

endpackage

### rtl/dnbsm_ram.sv
module dnbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read before write on the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/decaying_neighbour_blur_with_sprite_max_top.sv
// Flow: an item taken into the entry registers is computed in the compute stage and written
// into the output queue, from which its result is shown.
// Throughput: one item per cycle while the output queue has room, set by one read-modify-write
// pass per item through the line memories (registered read, row write in the cycle after entry,
// forwarding on the row buffer). Reset: synchronous, active low; clears control state, then a
// clearing pass zeroes the line memories while input is stalled; register writes are taken throughout.
module decaying_neighbour_blur_with_sprite_max_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dnbsm_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dnbsm_pkg::t_out_item          o_out_item,
    input  logic                          i_cfg_we,
    input  dnbsm_pkg::t_cfg_index         i_cfg_index,
    input  logic [dnbsm_pkg::SIZE_W-1:0]  i_cfg_data
);

    import dnbsm_pkg::*;

    // column index, row index, and the widths that can hold the sizes themselves
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = CW + 1;
    localparam int HW = RW + 1;
    localparam int XW = (SW > SIZE_W) ? SW : SIZE_W;
    localparam int XH = (HW > SIZE_W) ? HW : SIZE_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  r_frame_width;
    logic [SIZE_W-1:0]  r_frame_height;
    logic [DECAY_W-1:0] r_decay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_decay        <= RST_DECAY_AMOUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_DECAY_AMOUNT: r_decay        <= i_cfg_data[DECAY_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // Clamp the sizes in use to MIN_SIZE..MAX.
    logic [XW-1:0] wx;
    logic [XH-1:0] hx;
    logic [SW-1:0] w;
    logic [HW-1:0] h;

    always_comb begin
        wx = XW'(r_frame_width);
        hx = XH'(r_frame_height);
        if (wx < XW'(MIN_SIZE)) begin
            w = SW'(MIN_SIZE);
        end else if (wx > XW'(MAX_WIDTH)) begin
            w = SW'(MAX_WIDTH);
        end else begin
            w = SW'(wx);
        end
        if (hx < XH'(MIN_SIZE)) begin
            h = HW'(MIN_SIZE);
        end else if (hx > XH'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(hx);
        end
    end

    // ------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------
    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_clr_addr, n_clr_addr;
    logic          clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_phase    <= n_phase;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_clr_addr = r_clr_addr;
        case (r_phase)
            PH_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    n_phase    = PH_RUN;
                    n_clr_addr = '0;
                end
            end
            PH_RUN: ;
            default: n_phase = PH_CLEAR;
        endcase
    end

    assign clearing = (r_phase == PH_CLEAR);

    // ------------------------------------------------------------------
    // input handshake and output queue occupancy
    // ------------------------------------------------------------------
    logic [OQ_CW-1:0] r_oq_cnt;
    logic [OQ_AW-1:0] r_oq_wr;
    logic [OQ_AW-1:0] r_oq_rd;
    t_out_item        r_oq [OQ_DEPTH];
    logic             r_b_valid;
    logic [CW-1:0]    r_b_wi;
    logic             acc;
    logic             pop;

    // Stall while the queue plus the item in flight leaves no room for one more.
    assign o_in_stall = clearing ||
                        ((r_oq_cnt + OQ_CW'(r_b_valid)) > OQ_CW'(OQ_FILL_MAX));
    assign acc        = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // raster state
    // ------------------------------------------------------------------
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic [CW:0]        r_primed, n_primed;
    logic [2*PIX_W-1:0] r_olp;          // last two old pixels, newest low
    logic [PIX_W-1:0]   r_spr_hold;     // newest sprite, one ahead of the delay line
    logic [PIX_W-1:0]   r_new_left;     // last new value, committed to the row one item late
    logic [PIX_W-1:0]   r_old_center;   // old value of the output position

    // ------------------------------------------------------------------
    // entry stage: position of the output pixel, addresses, flags
    // ------------------------------------------------------------------
    logic [SW-1:0]     a_c1;
    logic [HW-1:0]     a_r1;
    logic [CW-1:0]     a_pc;
    logic [RW-1:0]     a_pr;
    logic [SW-1:0]     a_pc1;
    logic [SW-1:0]     a_w1;
    logic [CW-1:0]     a_wi;
    logic [CW-1:0]     a_raddr [3];
    logic [2:0]        a_fwd;
    logic              a_interior;
    logic              a_vout;
    logic              a_last;
    logic [PSUM_W-1:0] a_psum;

    always_comb begin
        a_c1 = {1'b0, r_col} + 1'b1;
        a_r1 = {1'b0, r_row} + 1'b1;

        // the output lags the input by one row and one pixel
        if (r_col != '0) begin
            a_pc = r_col - 1'b1;
            a_pr = (r_row != '0) ? r_row - 1'b1 : RW'(h - 1'b1);
        end else begin
            a_pc = CW'(w - 1'b1);
            if (r_row >= RW'(2)) begin
                a_pr = r_row - RW'(2);
            end else if (r_row == RW'(1)) begin
                a_pr = RW'(h - 1'b1);
            end else begin
                a_pr = RW'(h - HW'(2));
            end
        end

        a_interior = (a_pr != '0) && ((HW'(a_pr) + HW'(EDGE_GAP)) <= h) &&
                     (a_pc != '0) && ((SW'(a_pc) + SW'(EDGE_GAP)) <= w);

        // three taps of the updated row above; out-of-range taps read entry zero
        a_pc1      = SW'(a_pc) + 1'b1;
        a_raddr[0] = (a_pc != '0) ? a_pc - 1'b1 : '0;
        a_raddr[1] = a_pc;
        a_raddr[2] = (a_pc1 < SW'(MAX_WIDTH)) ? CW'(a_pc1) : '0;

        // where the previous new value lands in the row buffer
        a_wi = (a_pc == '0) ? CW'(w - 1'b1) : a_pc - 1'b1;

        // forward a row write that retires in this very cycle
        for (int j = 0; j < 3; j++) begin
            a_fwd[j] = r_b_valid && (r_b_wi == a_raddr[j]);
        end

        a_w1     = w + 1'b1;
        a_vout   = (r_primed >= a_w1);
        a_last   = a_vout && (HW'(a_pr) == h - 1'b1) && (SW'(a_pc) == w - 1'b1);
        n_primed = (r_primed < a_w1) ? r_primed + 1'b1 : r_primed;

        if (a_c1 >= w) begin
            n_col = '0;
            n_row = (a_r1 >= h) ? '0 : RW'(a_r1);
        end else begin
            n_col = CW'(a_c1);
            n_row = r_row;
        end

        // pre-add the left pair and the newest old pixel
        a_psum = PSUM_W'(i_in_item.old_pixel) + PSUM_W'(r_olp[PIX_W-1:0]) +
                 PSUM_W'(r_olp[2*PIX_W-1:PIX_W]);
    end

    // ------------------------------------------------------------------
    // line memories
    // ------------------------------------------------------------------
    // Old pixel delayed by W (high byte) and sprite delayed by W+1 (low byte) share
    // one address; read and write the same entry in the entry cycle.
    logic [2*PIX_W-1:0] old_rdata;

    dnbsm_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_old (
        .i_clk   (i_clk),
        .i_we    (clearing || acc),
        .i_waddr (clearing ? r_clr_addr : r_col),
        .i_wdata (clearing ? '0 : {i_in_item.old_pixel, r_spr_hold}),
        .i_raddr (r_col),
        .o_rdata (old_rdata)
    );

    // Updated row above, one copy per tap, all written alike in the cycle after entry.
    logic [PIX_W-1:0] row_rdata [3];

    for (genvar g = 0; g < 3; g++) begin : g_row
        dnbsm_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram_row (
            .i_clk   (i_clk),
            .i_we    (clearing || r_b_valid),
            .i_waddr (clearing ? r_clr_addr : r_b_wi),
            .i_wdata (clearing ? '0 : r_new_left),
            .i_raddr (a_raddr[g]),
            .o_rdata (row_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // entry registers
    // ------------------------------------------------------------------
    logic              r_b_interior;
    logic              r_b_vout;
    logic              r_b_last;
    logic [PSUM_W-1:0] r_b_psum;
    logic [2:0]        r_b_fwd;
    logic [PIX_W-1:0]  r_b_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_primed   <= '0;
            r_olp      <= '0;
            r_spr_hold <= '0;
            r_b_valid  <= 1'b0;
        end else begin
            r_b_valid <= acc;
            if (acc) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_primed   <= n_primed;
                r_olp      <= {r_olp[PIX_W-1:0], i_in_item.old_pixel};
                r_spr_hold <= i_in_item.sprite_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_wi       <= a_wi;
            r_b_interior <= a_interior;
            r_b_vout     <= a_vout;
            r_b_last     <= a_last;
            r_b_psum     <= a_psum;
            r_b_fwd      <= a_fwd;
            r_b_fwd_data <= r_new_left;
        end
    end

    // ------------------------------------------------------------------
    // compute stage: blur, decay, sprite maximum
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] b_row [3];
    logic [PIX_W-1:0] b_right;
    logic [PIX_W-1:0] b_spr;
    logic [SUM_W-1:0] b_sum;
    logic [PIX_W-1:0] b_avg;
    logic [PIX_W-1:0] b_blur;
    logic [PIX_W-1:0] b_nv;
    logic [PIX_W-1:0] b_res;
    t_out_item        b_item;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            b_row[j] = r_b_fwd[j] ? r_b_fwd_data : row_rdata[j];
        end
        b_right = old_rdata[2*PIX_W-1:PIX_W];
        b_spr   = old_rdata[PIX_W-1:0];

        b_sum = SUM_W'(r_b_psum) + SUM_W'(b_row[0]) + SUM_W'(b_row[1]) +
                SUM_W'(b_row[2]) + SUM_W'(r_new_left) + SUM_W'(b_right);
        b_avg = PIX_W'(b_sum >> AVG_SHIFT);

        // subtract the decay, floor at zero
        b_blur = (b_avg > r_decay) ? b_avg - r_decay : '0;
        b_nv   = r_b_interior ? b_blur : r_old_center;
        b_res  = (b_nv > b_spr) ? b_nv : b_spr;

        // hold the result at zero until the delay is primed
        b_item.new_pixel  = r_b_vout ? b_res : '0;
        b_item.out_valid  = r_b_vout;
        b_item.frame_last = r_b_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_left   <= '0;
            r_old_center <= '0;
        end else if (r_b_valid) begin
            r_new_left   <= b_nv;
            r_old_center <= b_right;
        end
    end

    // ------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_cnt <= '0;
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
        end else begin
            if (r_b_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(r_b_valid) - OQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_oq[r_oq_wr] <= b_item;
        end
    end

    assign o_out_valid = (r_oq_cnt != '0);
    assign o_out_item  = r_oq[r_oq_rd];

endmodule

### rtl/dnbsm_chk.sv
module dnbsm_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input dnbsm_pkg::t_out_item o_out_item
);

    import dnbsm_pkg::*;

    logic [OQ_CW-1:0] r_pend;   // items accepted and not yet taken

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + OQ_CW'(i_in_valid && !o_in_stall)
                             - OQ_CW'(o_out_valid && !i_out_stall);
        end
    end

    a_unprimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.out_valid |->
            (o_out_item.new_pixel == '0) && !o_out_item.frame_last)
        else $error("unprimed item carries data");

    a_last_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_last |-> o_out_item.out_valid)
        else $error("frame end flagged before priming");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0))
        else $error("result shown with no item pending");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= OQ_CW'(OQ_DEPTH - 1))
        else $error("more items in flight than the queue can hold");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind decaying_neighbour_blur_with_sprite_max_top dnbsm_chk u_dnbsm_chk (.*);

### tb/trail_blur_checker.sv
`timescale 1ns / 100ps

module trail_blur_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  dnbsm_pkg::t_in_item           i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  dnbsm_pkg::t_out_item          i_out_item,
    input  logic                          i_cfg_we,
    input  dnbsm_pkg::t_cfg_index         i_cfg_index,
    input  logic [dnbsm_pkg::SIZE_W-1:0]  i_cfg_data,
    output int                            o_fail_count,
    output int                            o_outstanding
);

    import dnbsm_pkg::*;

    logic [PIX_W-1:0]   row_above   [MAX_WIDTH];
    logic [PIX_W-1:0]   old_line    [MAX_WIDTH];
    logic [PIX_W-1:0]   sprite_line [MAX_WIDTH+1];
    logic [15:0]        old_pair;
    logic [PIX_W-1:0]   left_new;
    logic [PIX_W-1:0]   mid_old;
    int unsigned        row_pos;
    int unsigned        col_pos;
    int unsigned        primed;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [DECAY_W-1:0] decay_reg;
    t_out_item          pending_pixels [$];
    int                 errors;

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // out-of-range line indices fall back to entry 0
    function automatic int unsigned line_ix(input int unsigned i);
        return (i < MAX_WIDTH) ? i : 0;
    endfunction

    task automatic clear_state();
        for (int k = 0; k < MAX_WIDTH; k++) begin
            row_above[k] = '0;
            old_line[k]  = '0;
        end
        for (int k = 0; k <= MAX_WIDTH; k++) sprite_line[k] = '0;
        old_pair   = '0;
        left_new   = '0;
        mid_old    = '0;
        row_pos    = 0;
        col_pos    = 0;
        primed     = 0;
        width_reg  = RST_FRAME_WIDTH;
        height_reg = RST_FRAME_HEIGHT;
        decay_reg  = RST_DECAY_AMOUNT;
        pending_pixels.delete();
    endtask

    // advance the blur by one pixel and return the pixel leaving W+1 items back
    function automatic t_out_item blur_step(input t_in_item it);
        int unsigned w, h, r, c, pr, pc, right_old, centre, spr_out, nv, sum, res;
        logic        ready, inner;
        t_out_item   o;
        w = fit_size(width_reg, MAX_WIDTH);
        h = fit_size(height_reg, MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        ready = primed >= w + 1;
        if (c >= 1) begin
            pc = c - 1;
            pr = (r >= 1) ? r - 1 : h - 1;
        end else begin
            pc = w - 1;
            pr = (r >= 2) ? r - 2 : ((r == 1) ? h - 1 : h - 2);
        end

        right_old = old_line[line_ix(c)];
        old_line[line_ix(c)] = it.old_pixel;
        centre  = mid_old;
        mid_old = right_old;

        spr_out = sprite_line[line_ix(c)];
        sprite_line[line_ix(c)] = sprite_line[MAX_WIDTH];
        sprite_line[MAX_WIDTH]  = it.sprite_pixel;

        inner = pr >= 1 && pr + EDGE_GAP <= h && pc >= 1 && pc + EDGE_GAP <= w;
        if (inner) begin
            sum = row_above[line_ix(pc - 1)] + row_above[line_ix(pc)]
                + row_above[line_ix(pc + 1)] + left_new + right_old
                + old_pair[7:0] + old_pair[15:8] + it.old_pixel;
            sum = sum >> AVG_SHIFT;
            nv  = (sum > decay_reg) ? sum - decay_reg : 0;
        end else begin
            nv = centre;
        end

        // previous new value lands in the row buffer one item late
        row_above[line_ix((pc == 0) ? w - 1 : pc - 1)] = left_new;
        left_new = nv[PIX_W-1:0];
        old_pair = {old_pair[7:0], it.old_pixel};

        res = (nv > spr_out) ? nv : spr_out;
        o.new_pixel  = ready ? res[PIX_W-1:0] : '0;
        o.out_valid  = ready;
        o.frame_last = ready && pr == h - 1 && pc == w - 1;

        if (primed < w + 1) primed++;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        return o;
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_pixels.size() == 0) begin
            errors++;
            $error("result with no item outstanding: new_pixel %0d out_valid %0d frame_last %0d",
                   got.new_pixel, got.out_valid, got.frame_last);
        end else begin
            want = pending_pixels.pop_front();
            if (got.new_pixel !== want.new_pixel) begin
                errors++;
                $error("new_pixel: expected %0d, got %0d", want.new_pixel, got.new_pixel);
            end
            if (got.out_valid !== want.out_valid) begin
                errors++;
                $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
            end
            if (got.frame_last !== want.frame_last) begin
                errors++;
                $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    REG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    REG_DECAY_AMOUNT: decay_reg  = i_cfg_data[DECAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
            if (i_in_valid && !i_in_stall) pending_pixels.push_back(blur_step(i_in_item));
        end
        o_outstanding <= pending_pixels.size();
        o_fail_count  <= errors;
    end

endmodule

### tb/decaying_neighbour_blur_with_sprite_max_top_tb.sv
`timescale 1ns / 100ps

module decaying_neighbour_blur_with_sprite_max_top_tb;

    import dnbsm_pkg::*;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int ITEM_TARGET    = 1650;
    localparam int SETTLE_CYCLES  = 8;

    // register index the block has no register behind; writes to it must be ignored
    localparam t_cfg_index REG_SPARE = 2'd3;

    // flavours of pixel content for one phase
    typedef enum logic [1:0] {
        MIX_FULL,
        MIX_BRIGHT,
        MIX_SPARSE,
        MIX_EXTREME
    } t_mix;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        BACK_NONE,
        BACK_LIGHT,
        BACK_HEAVY,
        BACK_BURSTY
    } t_back;

    logic              i_clk      = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    t_in_item          in_item    = '0;
    logic              out_stall  = 1'b0;
    logic              cfg_we     = 1'b0;
    t_cfg_index        cfg_index  = REG_FRAME_WIDTH;
    logic [SIZE_W-1:0] cfg_data   = '0;
    logic              want_hold  = 1'b0;
    logic              calm_phase = 1'b0;
    int                sent       = 0;

    logic              in_stall;
    logic              out_valid;
    t_out_item         out_item;
    int                fail_count;
    int                outstanding;

    // 12 ns clock
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    decaying_neighbour_blur_with_sprite_max_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predicts every pixel from what crosses the ports and counts mismatches
    trail_blur_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Sender gap: mostly back-to-back, now and then a short pause, rarely a long one.
    // Calm phases offer an item every cycle.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_phase) return 0;
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input t_mix mix);
        case (mix)
            MIX_BRIGHT:  return PIX_W'($urandom_range(200, 255));
            MIX_SPARSE:  return ($urandom_range(0, 4) == 0) ? 8'hFF : 8'h00;
            MIX_EXTREME: return ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h00;
            default:     return PIX_W'($urandom);
        endcase
    endfunction

    // keep sprites mostly clear so that the blurred value shows through
    function automatic logic [PIX_W-1:0] pick_sprite(input t_mix mix);
        if ($urandom_range(0, 9) < 7) return 8'h00;
        if (mix == MIX_EXTREME) return 8'hFF;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_width();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return SIZE_W'($urandom_range(4, 12));
        if (roll < 90) return SIZE_W'($urandom_range(0, 3));
        return SIZE_W'($urandom_range(256, 511));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_height();
        if ($urandom_range(0, 9) < 8) return SIZE_W'($urandom_range(4, 9));
        return SIZE_W'($urandom_range(0, 511));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_decay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return SIZE_W'($urandom_range(0, 8));
        if (roll < 60) return '0;
        if (roll < 80) return ($urandom_range(0, 1) == 0) ? 9'd255 : 9'd511;
        return SIZE_W'($urandom_range(0, 511));
    endfunction

    // Offer one item and hold it until taken. Called at a rising edge; returns at the
    // edge that accepted the item, with valid still high so the next item can follow.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] spr);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid               <= 1'b1;
        in_item.old_pixel      <= pix;
        in_item.sprite_pixel   <= spr;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
    endtask

    // Wait until every expected pixel has come back.
    task automatic wait_idle();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Leave the write enable high between back-to-back writes; configure drops it once.
    task automatic put_reg(input t_cfg_index idx, input logic [SIZE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [SIZE_W-1:0] d);
        put_reg(REG_FRAME_WIDTH, w);
        put_reg(REG_FRAME_HEIGHT, h);
        put_reg(REG_DECAY_AMOUNT, d);
        if ($urandom_range(0, 3) == 0) put_reg(REG_SPARE, SIZE_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // One phase: set the frame, stream n items, drain. Phases rarely end on a frame
    // boundary, so each size change lands mid-stream.
    task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [SIZE_W-1:0] d, input int n, input t_mix mix);
        configure(w, h, d);
        for (int k = 0; k < n; k++) send_pixel(pick_pixel(mix), pick_sprite(mix));
        in_valid <= 1'b0;
        wait_idle();
    endtask

    // Receiver: stretches of differing back-pressure, plus one long hold-off on request.
    initial begin : receiver
        int    span;
        t_back back;
        logic  held;
        held = 1'b0;
        forever begin
            span = $urandom_range(8, 80);
            back = t_back'($urandom_range(0, 3));
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (want_hold && !held) begin
                    // hold off long enough for the block to fill and stall its input
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    out_stall <= 1'b0;
                end else begin
                    case (back)
                        BACK_NONE:  out_stall <= 1'b0;
                        BACK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                        BACK_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
                        default: begin
                            if ($urandom_range(0, 39) == 0) begin
                                out_stall <= 1'b1;
                                repeat ($urandom_range(10, 40)) @(posedge i_clk);
                            end
                            out_stall <= 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset frame size: nothing is primed yet, so these leave as blanks.
        send_pixel(8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00);
        send_pixel(8'h00, 8'hFF);
        send_pixel(8'h55, 8'hAA);
        send_pixel(8'hAA, 8'h55);
        in_valid <= 1'b0;
        wait_idle();

        // Sizes below the minimum clamp to a 4x4 frame with a single inner pixel;
        // one full bright frame, sprite at the bottom-right corner.
        configure(9'd3, 9'd0, 9'd0);
        for (int k = 0; k < 16; k++) send_pixel(8'hFF, (k == 15) ? 8'hFF : 8'h00);
        in_valid <= 1'b0;
        wait_idle();

        // Long receiver hold-off while the sender keeps offering every cycle.
        calm_phase = 1'b1;
        want_hold <= 1'b1;
        run_phase(9'd8, 9'd6, 9'd2, 200, MIX_FULL);
        calm_phase = 1'b0;

        // Widest line: output drops out until the wider delay line has primed again.
        run_phase(9'd256, 9'd4, 9'd0, 560, MIX_FULL);

        // Tallest frame, oversize height clamped, decay written with its spare bit set.
        run_phase(9'd4, 9'd511, 9'h1FF, 150, MIX_BRIGHT);

        // Random phases until the item budget is spent.
        while (sent < ITEM_TARGET) begin
            logic [SIZE_W-1:0] w;
            w = pick_width();
            n = (w >= 13) ? $urandom_range(30, 60) : $urandom_range(20, 120);
            calm_phase = ($urandom_range(0, 3) == 0);
            run_phase(w, pick_height(), pick_decay(), n, t_mix'($urandom_range(0, 3)));
        end
        calm_phase = 1'b0;

        // Drain, then let stragglers show up.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
